// ----- rtl/torq_pkg.sv -----
// ----------------------------------------------------------------------------
// torq_pkg: shared types and codes of the timestamp ordered request queue
// Entry layout, command and status codes, register indexes and the width
// helpers used by the queue, its entry memory and its port checker.
// ----------------------------------------------------------------------------
package torq_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int STAMP_W   = 32;
  localparam int SOURCE_W  = 8;
  localparam int PAYLOAD_W = 32;
  localparam int KIND_W    = 3;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int RANK_W    = 8;
  localparam int FIRST_N_W = 5;

  // one stored request
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [SOURCE_W-1:0]  source;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_OWN_RANK = 1'b0;
  localparam logic REG_FIRST_N  = 1'b1;

  // bits of an occupancy count that can reach the depth itself
  function automatic int cnt_width(input int depth);
    return $clog2(depth + 1);
  endfunction

  // result tdata width, whole bytes
  function automatic int out_data_width(input int depth);
    int raw;
    raw = 2 * cnt_width(depth) + 2 + STAMP_W + SOURCE_W + PAYLOAD_W;
    return ((raw + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/torq_ram.sv -----
// ----------------------------------------------------------------------------
// torq_ram: entry memory of the request queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module torq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  torq_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output torq_pkg::entry_t rdata_o
);
  import torq_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/timestamp_ordered_request_queue.sv -----
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue: sorted request queue for mutual exclusion
// Insert, pop and remove-by-source on a (stamp, source) ordered queue held in
// one memory, with a report of occupancy, head entry and own admission.
// ----------------------------------------------------------------------------
// Each request runs a walk, a prepare step and a scan, then posts its result. Walk:
// insert shifts larger entries up from the tail (or writes the head of an empty queue),
// pop shifts entries down, remove compacts; none for a dropped insert, a pop on empty or
// an unused command. Scan: reads the head and admitted places of the new queue, none when
// empty. Input is ready again as the result posts; it waits in the output register while the next enters.
// Reset clears occupancy, control state and registers; entries need no clear.
module timestamp_ordered_request_queue #(
  parameter int QUEUE_DEPTH = torq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // stamp[31:0], source[39:32], payload[71:40], zero pad [79:72]
  input  logic [79:0] s_axis_tdata,
  // command[1:0], kind[4:2]
  input  logic [4:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // occupancy, removed_count, own_admitted, head_valid, head_stamp,
  // head_source, head_payload, zero pad to whole bytes
  output logic [torq_pkg::out_data_width(QUEUE_DEPTH)-1:0] m_axis_tdata,
  // status[1:0], head_kind[4:2]
  output logic [4:0]  m_axis_tuser,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import torq_pkg::*;

  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int CntW    = cnt_width(QUEUE_DEPTH);
  localparam int LimW    = (CntW > FIRST_N_W) ? CntW : FIRST_N_W;
  localparam int OutW    = out_data_width(QUEUE_DEPTH);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] CNT_ONE  = CntW'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  entry_t              newe_q, newe_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     left_q, left_d;
  logic                pend_q, pend_d;
  logic [CntW-1:0]     pidx_q, pidx_d;
  logic [CntW-1:0]     keep_q, keep_d;
  logic [CntW-1:0]     removed_q, removed_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                adm_q, adm_d;
  entry_t              head_q, head_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [CntW-1:0]     out_occ_q, out_occ_d;
  logic [CntW-1:0]     out_rem_q, out_rem_d;
  logic                out_adm_q, out_adm_d;
  logic                out_hv_q, out_hv_d;
  entry_t              out_head_q, out_head_d;

  logic [RANK_W-1:0]    own_rank_q;
  logic [FIRST_N_W-1:0] first_n_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  logic            accept;
  logic            issue;
  logic            precedes;
  logic            cfg_wr;
  entry_t          in_entry;
  logic [LimW-1:0] lim;
  logic [CntW-1:0] scan_len;
  logic [CntW-1:0] pidx_up;
  logic [CntW-1:0] pidx_dn;

  torq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_OWN_RANK: prdata = 32'(own_rank_q);
      REG_FIRST_N:  prdata = 32'(first_n_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_rank_q <= '0;
      first_n_q  <= FIRST_N_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_OWN_RANK) begin
        own_rank_q <= pwdata[RANK_W-1:0];
      end else begin
        first_n_q <= pwdata[FIRST_N_W-1:0];
      end
    end
  end

  // input unpack
  assign s_axis_tready    = (state_q == S_IDLE);
  assign accept           = s_axis_tvalid && s_axis_tready;
  assign in_entry.stamp   = s_axis_tdata[31:0];
  assign in_entry.source  = s_axis_tdata[39:32];
  assign in_entry.payload = s_axis_tdata[71:40];
  assign in_entry.kind    = s_axis_tuser[4:2];

  // ordering compare of the entry just read against the new request
  assign precedes = (mem_rdata.stamp < newe_q.stamp) ||
                    ((mem_rdata.stamp == newe_q.stamp) &&
                     (mem_rdata.source < newe_q.source));

  // admitted places and scan length
  assign lim      = (LimW'(first_n_q) < LimW'(cnt_q)) ? LimW'(first_n_q) : LimW'(cnt_q);
  assign scan_len = (lim == '0) ? CNT_ONE : CntW'(lim);
  assign pidx_up  = pidx_q + CNT_ONE;
  assign pidx_dn  = pidx_q - CNT_ONE;

  // reads are issued one per cycle while the walk or scan has some left
  assign issue = ((state_q == S_WALK) || (state_q == S_SCAN)) && (left_q != '0);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    newe_d    = newe_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    left_d    = left_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    keep_d    = keep_q;
    removed_d = removed_q;
    status_d  = status_q;
    adm_d     = adm_q;
    head_d    = head_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    out_rem_d    = out_rem_q;
    out_adm_d    = out_adm_q;
    out_hv_d     = out_hv_q;
    out_head_d   = out_head_q;

    if (issue) begin
      left_d = left_q - CNT_ONE;
      pend_d = 1'b1;
      pidx_d = rd_q;
      rd_d   = (cmd_q == CMD_INSERT && state_q == S_WALK) ? rd_q - CNT_ONE
                                                          : rd_q + CNT_ONE;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = s_axis_tuser[1:0];
          newe_d    = in_entry;
          status_d  = ST_DONE;
          removed_d = '0;
          keep_d    = '0;
          case (s_axis_tuser[1:0])
            CMD_INSERT: begin
              if (cnt_q == CNT_FULL) begin
                status_d = ST_FULL;
                state_d  = S_PREP;
              end else if (cnt_q == '0) begin
                state_d = S_INS0;
              end else begin
                rd_d    = cnt_q - CNT_ONE;
                left_d  = cnt_q;
                state_d = S_WALK;
              end
            end
            CMD_POP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_PREP;
              end else begin
                rd_d    = CNT_ONE;
                left_d  = cnt_q - CNT_ONE;
                state_d = S_WALK;
              end
            end
            CMD_REMOVE: begin
              rd_d    = '0;
              left_d  = cnt_q;
              state_d = S_WALK;
            end
            default: begin
              state_d = S_PREP;
            end
          endcase
        end
      end

      S_WALK: begin
        case (cmd_q)
          // walk down from the tail, shifting larger entries up one place
          CMD_INSERT: begin
            if (pend_q) begin
              mem_we    = 1'b1;
              mem_waddr = pidx_up[AW-1:0];
              if (precedes) begin
                mem_wdata = newe_q;
                cnt_d     = cnt_q + CNT_ONE;
                state_d   = S_PREP;
              end else if (pidx_q == '0) begin
                state_d = S_INS0;
              end
            end
          end
          // shift every entry behind the head down one place
          CMD_POP: begin
            if (pend_q) begin
              mem_we    = 1'b1;
              mem_waddr = pidx_dn[AW-1:0];
            end
            if (left_q == '0 && !pend_q) begin
              cnt_d     = cnt_q - CNT_ONE;
              removed_d = CNT_ONE;
              state_d   = S_PREP;
            end
          end
          // compact the entries whose source differs
          default: begin
            if (pend_q) begin
              if (mem_rdata.source == newe_q.source) begin
                removed_d = removed_q + CNT_ONE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = keep_q[AW-1:0];
                keep_d    = keep_q + CNT_ONE;
              end
            end
            if (left_q == '0 && !pend_q) begin
              cnt_d   = keep_q;
              state_d = S_PREP;
            end
          end
        endcase
      end

      // new request lands at the head
      S_INS0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = newe_q;
        cnt_d     = cnt_q + CNT_ONE;
        state_d   = S_PREP;
      end

      S_PREP: begin
        rd_d    = '0;
        left_d  = (cnt_q == '0) ? '0 : scan_len;
        adm_d   = 1'b0;
        head_d  = '0;
        state_d = S_SCAN;
      end

      // read the head and the admitted places, then post the result
      S_SCAN: begin
        if (pend_q) begin
          if (pidx_q == '0) begin
            head_d = mem_rdata;
          end
          if (LimW'(pidx_q) < lim && mem_rdata.source == own_rank_q) begin
            adm_d = 1'b1;
          end
        end
        if (left_q == '0 && !pend_q && (!out_valid_q || m_axis_tready)) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_occ_d    = cnt_q;
          out_rem_d    = removed_q;
          out_adm_d    = adm_q;
          out_hv_d     = (cnt_q != '0);
          out_head_d   = head_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result data
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    newe_q       <= newe_d;
    rd_q         <= rd_d;
    pidx_q       <= pidx_d;
    keep_q       <= keep_d;
    removed_q    <= removed_d;
    status_q     <= status_d;
    adm_q        <= adm_d;
    head_q       <= head_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
    out_rem_q    <= out_rem_d;
    out_adm_q    <= out_adm_d;
    out_hv_q     <= out_hv_d;
    out_head_q   <= out_head_d;
  end

  // result pack
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_head_q.payload, out_head_q.source, out_head_q.stamp,
                                out_hv_q, out_adm_q, out_rem_q, out_occ_q});
  assign m_axis_tuser  = {out_head_q.kind, out_status_q};

endmodule

// ----- rtl/torq_checker.sv -----
// ----------------------------------------------------------------------------
// torq_checker: port checker of the request queue
// Checks the consistency of result items seen on the master-side port.
// ----------------------------------------------------------------------------
module torq_checker #(
  parameter int QUEUE_DEPTH = torq_pkg::DEFAULT_DEPTH
) (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [torq_pkg::out_data_width(QUEUE_DEPTH)-1:0] m_axis_tdata,
  input logic [4:0] m_axis_tuser
);
  import torq_pkg::*;

  localparam int CntW = cnt_width(QUEUE_DEPTH);
  localparam int OffS = 2 * CntW + 2;

  logic [CntW-1:0]      occ;
  logic [CntW-1:0]      rem;
  logic                 adm;
  logic                 hv;
  logic [STATUS_W-1:0]  status;
  logic                 head_zero;

  assign occ       = m_axis_tdata[CntW-1:0];
  assign rem       = m_axis_tdata[2*CntW-1:CntW];
  assign adm       = m_axis_tdata[2*CntW];
  assign hv        = m_axis_tdata[2*CntW+1];
  assign status    = m_axis_tuser[1:0];
  assign head_zero = (m_axis_tdata[OffS+STAMP_W+SOURCE_W+PAYLOAD_W-1:OffS] == '0) &&
                     (m_axis_tuser[4:2] == '0);

  // occupancy stays within the queue depth
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> occ <= CntW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // head valid follows the occupancy
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> hv == (occ != '0))
    else $error("head_valid does not match occupancy");

  // an empty queue reports a zero head and no admission
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hv |-> head_zero && !adm)
    else $error("empty queue reports head data or admission");

  // a dropped insert only happens on a full queue and removes nothing
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_FULL |-> occ == CntW'(QUEUE_DEPTH) && rem == '0)
    else $error("insert dropped while not full");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind timestamp_ordered_request_queue torq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_torq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
